FILE: rtl/core/csa_pkg.sv
// Shared types, constants and functions of the clock set block.
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

	localparam int COUNT_W = 11;
	localparam int MPH_W = 6;
	localparam int PERIOD_W = 10;
	localparam int TIMER_W = 10;
	localparam int CMP_W = (TIMER_W > PERIOD_W) ? TIMER_W : PERIOD_W;
	localparam int MODE_W = 2;
	localparam int HOURS_PER_DAY = 24;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_MPH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RUN_PERIOD = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_DELAY = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd3;

	localparam logic [MPH_W-1:0] MPH_RESET = 6'd30;
	localparam logic [PERIOD_W-1:0] RUN_PERIOD_RESET = 10'd100;
	localparam logic [PERIOD_W-1:0] HOLD_DELAY_RESET = 10'd500;
	localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RESET = 10'd100;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd2;

	localparam logic [MODE_W-1:0] CODE_RUN = 2'd0;
	localparam logic [MODE_W-1:0] CODE_HOURS = 2'd1;
	localparam logic [MODE_W-1:0] CODE_MINUTES = 2'd2;

	typedef enum logic [2:0] {
		MODE_RUN = 3'b001,
		MODE_HOURS = 3'b010,
		MODE_MINUTES = 3'b100
	} mode_t;

	typedef struct packed {
		logic [MPH_W-1:0] mph;
		logic [PERIOD_W-1:0] run_period;
		logic [PERIOD_W-1:0] hold_delay;
		logic [PERIOD_W-1:0] repeat_period;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [COUNT_W-1:0] rem;
	} div_t;

	typedef struct packed {
		logic [TIMER_W-1:0] timer;
		logic pressed;
		logic holding;
	} key_t;

	typedef struct packed {
		key_t k;
		logic step;
	} key_res_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [MODE_W-1:0] mode;
		logic changed;
	} res_t;

	function automatic logic [COUNT_W-1:0] day_len(input logic [MPH_W-1:0] mph);
		return COUNT_W'(COUNT_W'(mph) * COUNT_W'(HOURS_PER_DAY));
	endfunction

	function automatic logic [TIMER_W-1:0] tick_up(input logic [TIMER_W-1:0] t);
		return (t == '1) ? t : t + TIMER_W'(1);
	endfunction

	function automatic key_res_t key_work(
		input logic level,
		input key_t k_in,
		input logic [PERIOD_W-1:0] hold,
		input logic [PERIOD_W-1:0] rep
	);
		key_res_t r;
		r.k = k_in;
		r.step = 1'b0;
		if (level) begin
			if (!r.k.pressed) begin
				r.k.pressed = 1'b1;
				r.k.timer = '0;
			end
			if (r.k.holding && (CMP_W'(r.k.timer) > CMP_W'(rep))) begin
				r.step = 1'b1;
				r.k.timer = '0;
			end else if (CMP_W'(r.k.timer) > CMP_W'(hold)) begin
				r.step = 1'b1;
				r.k.timer = '0;
				r.k.holding = 1'b1;
			end
		end else if (r.k.pressed && !r.k.holding) begin
			r.step = 1'b1;
			r.k.timer = '0;
			r.k.pressed = 1'b0;
		end else begin
			r.k.pressed = 1'b0;
			r.k.holding = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/csa_if.sv
// Stream interfaces for button ticks and clock results.
`timescale 1ns / 1ps
`default_nettype none

interface csa_in_if;
	logic valid;
	logic ready;
	logic mode_button;
	logic up_button;
	logic down_button;
	modport source(output valid, output mode_button, output up_button, output down_button,
		input ready);
	modport sink(input valid, input mode_button, input up_button, input down_button,
		output ready);
endinterface

interface csa_out_if;
	logic valid;
	logic ready;
	logic [csa_pkg::COUNT_W-1:0] minute_count;
	logic [csa_pkg::MODE_W-1:0] clock_mode;
	logic count_changed;
	modport source(output valid, output minute_count, output clock_mode, output count_changed,
		input ready);
	modport sink(input valid, input minute_count, input clock_mode, input count_changed,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/csa_cfg.sv
// APB register bank holding the four configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module csa_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [csa_pkg::ADDR_W-1:0] paddr,
	input wire logic [csa_pkg::DATA_W-1:0] pwdata,
	output logic [csa_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output csa_pkg::cfg_t cfg,
	output logic mph_wr
);

	csa_pkg::cfg_t cfg_q;
	logic wr;
	logic [csa_pkg::REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[csa_pkg::ADDR_W-1:2];
	assign mph_wr = wr && (idx == csa_pkg::REG_MPH);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mph <= csa_pkg::MPH_RESET;
			cfg_q.run_period <= csa_pkg::RUN_PERIOD_RESET;
			cfg_q.hold_delay <= csa_pkg::HOLD_DELAY_RESET;
			cfg_q.repeat_period <= csa_pkg::REPEAT_PERIOD_RESET;
		end else if (wr) begin
			case (idx)
				csa_pkg::REG_MPH: cfg_q.mph <= pwdata[csa_pkg::MPH_W-1:0];
				csa_pkg::REG_RUN_PERIOD: cfg_q.run_period <= pwdata[csa_pkg::PERIOD_W-1:0];
				csa_pkg::REG_HOLD_DELAY: cfg_q.hold_delay <= pwdata[csa_pkg::PERIOD_W-1:0];
				csa_pkg::REG_REPEAT_PERIOD: cfg_q.repeat_period <= pwdata[csa_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			csa_pkg::REG_MPH: prdata = csa_pkg::DATA_W'(cfg_q.mph);
			csa_pkg::REG_RUN_PERIOD: prdata = csa_pkg::DATA_W'(cfg_q.run_period);
			csa_pkg::REG_HOLD_DELAY: prdata = csa_pkg::DATA_W'(cfg_q.hold_delay);
			csa_pkg::REG_REPEAT_PERIOD: prdata = csa_pkg::DATA_W'(cfg_q.repeat_period);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/csa_rem.sv
// Bit-serial remainder unit that reduces the count modulo the day length.
`timescale 1ns / 1ps
`default_nettype none

module csa_rem (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [csa_pkg::COUNT_W-1:0] count,
	input wire logic [csa_pkg::COUNT_W-1:0] day,
	output csa_pkg::div_t stat
);

	localparam int CNT_W = $clog2(csa_pkg::COUNT_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [csa_pkg::COUNT_W-1:0] rem_q;
	logic [csa_pkg::COUNT_W-1:0] quo_q;
	logic [csa_pkg::COUNT_W:0] rem_sh;
	logic [csa_pkg::COUNT_W:0] rem_n;

	always_comb begin
		rem_sh = {rem_q, quo_q[csa_pkg::COUNT_W-1]};
		if (rem_sh >= {1'b0, day}) begin
			rem_n = rem_sh - {1'b0, day};
		end else begin
			rem_n = rem_sh;
		end
		stat.busy = (cnt_q != '0);
		stat.done = (cnt_q == CNT_W'(1));
		stat.rem = rem_n[csa_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(csa_pkg::COUNT_W);
		end else if (stat.busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= count;
		end else if (stat.busy) begin
			rem_q <= rem_n[csa_pkg::COUNT_W-1:0];
			quo_q <= {quo_q[csa_pkg::COUNT_W-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/csa_core.sv
// Clock state and the per-tick update of mode, keys, timers and count.
`timescale 1ns / 1ps
`default_nettype none

module csa_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire logic mode_button,
	input wire logic up_button,
	input wire logic down_button,
	input wire csa_pkg::cfg_t cfg,
	input wire csa_pkg::div_t div,
	output logic [csa_pkg::COUNT_W-1:0] count,
	output csa_pkg::res_t res
);

	csa_pkg::mode_t mode_q, mode_d;
	logic [csa_pkg::COUNT_W-1:0] count_q, count_d, red_q, step_val, day, delta;
	logic seen_q, seen_d, leave;
	logic [csa_pkg::TIMER_W-1:0] run_t_q, run_t_d, run_tick;
	csa_pkg::key_t up_q, up_d, dn_q, dn_d;
	csa_pkg::key_res_t up_r, dn_r;
	logic up_step, dn_step, run_step, changed;
	logic [csa_pkg::COUNT_W:0] sum_add, sum_sub;

	assign count = count_q;
	assign day = csa_pkg::day_len(cfg.mph);

	always_comb begin
		mode_d = mode_q;
		run_t_d = run_t_q;
		up_d = up_q;
		dn_d = dn_q;
		up_step = 1'b0;
		dn_step = 1'b0;
		run_step = 1'b0;
		leave = !mode_button && seen_q;
		seen_d = mode_button ? 1'b1 : (leave ? 1'b0 : seen_q);
		run_tick = csa_pkg::tick_up(run_t_q);
		up_r = csa_pkg::key_work(up_button,
			'{timer: csa_pkg::tick_up(up_q.timer), pressed: up_q.pressed, holding: up_q.holding},
			cfg.hold_delay, cfg.repeat_period);
		dn_r = csa_pkg::key_work(down_button,
			'{timer: csa_pkg::tick_up(dn_q.timer), pressed: dn_q.pressed, holding: dn_q.holding},
			cfg.hold_delay, cfg.repeat_period);

		if (leave) begin
			case (mode_q)
				csa_pkg::MODE_HOURS: mode_d = csa_pkg::MODE_MINUTES;
				csa_pkg::MODE_MINUTES: begin
					mode_d = csa_pkg::MODE_RUN;
					run_t_d = '0;
				end
				default: mode_d = csa_pkg::MODE_HOURS;
			endcase
			if (mode_d != csa_pkg::MODE_RUN) begin
				up_d = '{timer: '0, pressed: up_button, holding: 1'b0};
				dn_d = '{timer: '0, pressed: down_button, holding: 1'b0};
			end
		end else if (mode_q == csa_pkg::MODE_HOURS || mode_q == csa_pkg::MODE_MINUTES) begin
			up_d = up_r.k;
			dn_d = dn_r.k;
			up_step = up_r.step;
			dn_step = dn_r.step;
		end else begin
			run_t_d = run_tick;
			if (csa_pkg::CMP_W'(run_tick) >= csa_pkg::CMP_W'(cfg.run_period)) begin
				run_step = 1'b1;
				run_t_d = '0;
			end
		end

		// Run steps are always one unit; edit steps follow the edited field.
		if (run_step || mode_q != csa_pkg::MODE_HOURS) begin
			delta = csa_pkg::COUNT_W'(1);
		end else begin
			delta = csa_pkg::COUNT_W'(cfg.mph);
		end
		sum_add = {1'b0, red_q} + {1'b0, delta};
		if (sum_add >= {1'b0, day}) begin
			sum_add = sum_add - {1'b0, day};
		end
		sum_sub = {1'b0, red_q} + {1'b0, day} - {1'b0, delta};
		if (sum_sub >= {1'b0, day}) begin
			sum_sub = sum_sub - {1'b0, day};
		end

		// A zero hour length gives a zero day length, so every step lands on zero.
		if (cfg.mph == '0) begin
			step_val = '0;
		end else if (up_step && dn_step) begin
			step_val = red_q;
		end else if (dn_step) begin
			step_val = sum_sub[csa_pkg::COUNT_W-1:0];
		end else begin
			step_val = sum_add[csa_pkg::COUNT_W-1:0];
		end

		changed = up_step || dn_step || run_step;
		count_d = changed ? step_val : count_q;

		res.count = count_d;
		res.changed = changed;
		case (mode_d)
			csa_pkg::MODE_HOURS: res.mode = csa_pkg::CODE_HOURS;
			csa_pkg::MODE_MINUTES: res.mode = csa_pkg::CODE_MINUTES;
			default: res.mode = csa_pkg::CODE_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csa_pkg::MODE_RUN;
			count_q <= csa_pkg::COUNT_RESET;
			red_q <= csa_pkg::COUNT_RESET;
			seen_q <= 1'b0;
			run_t_q <= '0;
			up_q <= '0;
			dn_q <= '0;
		end else begin
			if (fire) begin
				mode_q <= mode_d;
				count_q <= count_d;
				seen_q <= seen_d;
				run_t_q <= run_t_d;
				up_q <= up_d;
				dn_q <= dn_d;
			end
			if (fire && changed) begin
				red_q <= step_val;
			end else if (div.done) begin
				red_q <= div.rem;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/clock_set_with_key_autorepeat.sv
// Top level of the clock set block with key autorepeat.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one millisecond tick carrying the three button levels and
// yields exactly one result transaction with the count, mode and a stepped flag. One
// transaction is taken per clock cycle while no remainder pass runs and the output
// does not stall: a tick is captured in an input register, and the single-pass update
// then writes the result register; an output stall holds the tick in the input register.
// Writing the minutes_per_hour register starts a bit-serial remainder pass that reduces
// the held count to the new day length; no tick is taken while it runs.

module clock_set_with_key_autorepeat (
	input wire logic clk,
	input wire logic arst_n,
	csa_in_if.sink in_ch,
	csa_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [csa_pkg::ADDR_W-1:0] paddr,
	input wire logic [csa_pkg::DATA_W-1:0] pwdata,
	output logic [csa_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	csa_pkg::cfg_t cfg;
	csa_pkg::div_t div;
	csa_pkg::res_t res;
	logic mph_wr;
	logic [csa_pkg::COUNT_W-1:0] count;
	logic valid_s1, mode_s1, up_s1, down_s1;
	logic out_valid_q;
	logic [csa_pkg::COUNT_W-1:0] count_q;
	logic [csa_pkg::MODE_W-1:0] mode_q;
	logic changed_q;
	logic advance, take;

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !div.busy && (!valid_s1 || advance);
	assign take = in_ch.valid && in_ch.ready;

	assign out_ch.valid = out_valid_q;
	assign out_ch.minute_count = count_q;
	assign out_ch.clock_mode = mode_q;
	assign out_ch.count_changed = changed_q;

	csa_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg),
		.mph_wr(mph_wr)
	);

	csa_rem u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(mph_wr),
		.count(count),
		.day(csa_pkg::day_len(cfg.mph)),
		.stat(div)
	);

	csa_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.mode_button(mode_s1),
		.up_button(up_s1),
		.down_button(down_s1),
		.cfg(cfg),
		.div(div),
		.count(count),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= in_ch.mode_button;
			up_s1 <= in_ch.up_button;
			down_s1 <= in_ch.down_button;
		end
		if (advance) begin
			count_q <= res.count;
			mode_q <= res.mode;
			changed_q <= res.changed;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the clock set block with key autorepeat.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import csa_pkg::*;

	localparam int TICK_GAP_MAX = 14;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES = 10;
	localparam int PHASE_TICKS = 12;
	localparam int LONG_HOLD_TICKS = 1030;
	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	typedef struct packed {
		logic [COUNT_W-1:0] minute_count;
		logic [MODE_W-1:0] clock_mode;
		logic count_changed;
	} clock_result_t;

	typedef struct packed {
		logic [TIMER_W-1:0] timer;
		logic pressed;
		logic holding;
	} key_track_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic mb;
		logic ub;
		logic db;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [DATA_W-1:0] value;
		logic typed;
		clock_result_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	csa_in_if in_ch();
	csa_out_if out_ch();

	clock_set_with_key_autorepeat u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [MPH_W-1:0] cfg_mph;
	logic [PERIOD_W-1:0] cfg_run;
	logic [PERIOD_W-1:0] cfg_hold;
	logic [PERIOD_W-1:0] cfg_repeat;
	logic [MODE_W-1:0] cur_mode;
	logic [COUNT_W-1:0] cur_count;
	logic mode_seen;
	logic [TIMER_W-1:0] run_timer;
	key_track_t up_key;
	key_track_t down_key;

	clock_result_t pending_results[$];
	directed_row_t directed_rows[$];
	int error_count = 0;
	int cycle_count = 0;
	int phase_ticks = 0;
	bit no_idle = 1'b0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [TIMER_W-1:0] timer_inc(input logic [TIMER_W-1:0] t);
		return (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] stepped_count(input logic [COUNT_W-1:0] cnt,
		input int delta, input bit down);
		int day;
		int c;
		int d;
		day = HOURS_PER_DAY * int'(cfg_mph);
		if (day == 0)
			day = 1;
		c = int'(cnt) % day;
		d = delta % day;
		return COUNT_W'(down ? (c + day - d) % day : (c + d) % day);
	endfunction

	function automatic bit key_advance(input bit level, inout key_track_t k);
		bit step;
		step = 1'b0;
		if (level) begin
			if (!k.pressed) begin
				k.pressed = 1'b1;
				k.timer = '0;
			end
			if (k.holding && k.timer > cfg_repeat) begin
				step = 1'b1;
				k.timer = '0;
			end else if (k.timer > cfg_hold) begin
				step = 1'b1;
				k.timer = '0;
				k.holding = 1'b1;
			end
		end else if (k.pressed && !k.holding) begin
			step = 1'b1;
			k.timer = '0;
			k.pressed = 1'b0;
		end else begin
			k.pressed = 1'b0;
			k.holding = 1'b0;
		end
		return step;
	endfunction

	// Advances the predicted clock state by one tick and returns the result it shows.
	function automatic clock_result_t predict_tick(input bit mb, input bit ub, input bit db);
		bit leave;
		bit stepped;
		int delta;
		clock_result_t r;
		leave = 1'b0;
		stepped = 1'b0;
		if (mb)
			mode_seen = 1'b1;
		else if (mode_seen)
			leave = 1'b1;
		if (leave) begin
			mode_seen = 1'b0;
			case (cur_mode)
				CODE_HOURS: cur_mode = CODE_MINUTES;
				CODE_MINUTES: begin
					cur_mode = CODE_RUN;
					run_timer = '0;
				end
				default: cur_mode = CODE_HOURS;
			endcase
			if (cur_mode != CODE_RUN) begin
				up_key = '{timer: '0, pressed: ub, holding: 1'b0};
				down_key = '{timer: '0, pressed: db, holding: 1'b0};
			end
		end else if (cur_mode == CODE_HOURS || cur_mode == CODE_MINUTES) begin
			delta = (cur_mode == CODE_HOURS) ? int'(cfg_mph) : 1;
			up_key.timer = timer_inc(up_key.timer);
			down_key.timer = timer_inc(down_key.timer);
			if (key_advance(ub, up_key)) begin
				cur_count = stepped_count(cur_count, delta, 1'b0);
				stepped = 1'b1;
			end
			if (key_advance(db, down_key)) begin
				cur_count = stepped_count(cur_count, delta, 1'b1);
				stepped = 1'b1;
			end
		end else begin
			run_timer = timer_inc(run_timer);
			if (run_timer >= cfg_run) begin
				cur_count = stepped_count(cur_count, 1, 1'b0);
				stepped = 1'b1;
				run_timer = '0;
			end
		end
		r.minute_count = cur_count;
		r.clock_mode = cur_mode;
		r.count_changed = stepped;
		return r;
	endfunction

	function automatic directed_row_t tick_row(input bit mb, input bit ub, input bit db);
		directed_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.mb = mb;
		r.ub = ub;
		r.db = db;
		return r;
	endfunction

	function automatic directed_row_t typed_row(input bit mb, input bit ub, input bit db,
		input int cnt, input logic [MODE_W-1:0] mode, input bit changed);
		directed_row_t r;
		r = tick_row(mb, ub, db);
		r.typed = 1'b1;
		r.want = '{minute_count: COUNT_W'(cnt), clock_mode: mode, count_changed: changed};
		return r;
	endfunction

	function automatic directed_row_t write_row(input logic [REG_IDX_W-1:0] idx,
		input int value);
		directed_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.value = DATA_W'(value);
		return r;
	endfunction

	task automatic send_tick(input bit mb, input bit ub, input bit db,
		input bit typed = 1'b0, input clock_result_t want = '0);
		int gap;
		clock_result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, TICK_GAP_MAX);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.mode_button <= mb;
		in_ch.up_button <= ub;
		in_ch.down_button <= db;
		do @(posedge clk); while (!in_ch.ready);
		predicted = predict_tick(mb, ub, db);
		pending_results.push_back(typed ? want : predicted);
		phase_ticks++;
	endtask

	// Lets the block drain so that a register may be written safely.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MPH: cfg_mph = value[MPH_W-1:0];
			REG_RUN_PERIOD: cfg_run = value[PERIOD_W-1:0];
			REG_HOLD_DELAY: cfg_hold = value[PERIOD_W-1:0];
			default: cfg_repeat = value[PERIOD_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		error_count++;
	endtask

	task automatic random_sequence();
		int len;
		bit ub;
		bit db;
		case ($urandom_range(0, 9))
			0, 1: begin
				repeat ($urandom_range(1, 3))
					send_tick(1'b1, $urandom_range(0, 1), $urandom_range(0, 1));
				send_tick(1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
			end
			2, 3: begin
				ub = $urandom_range(0, 1);
				repeat ($urandom_range(1, 3))
					send_tick(1'b0, ub, !ub);
				send_tick(1'b0, 1'b0, 1'b0);
			end
			4, 5, 6: begin
				ub = $urandom_range(0, 1);
				db = ($urandom_range(0, 3) == 0) ? 1'b1 : !ub;
				len = int'(cfg_hold) + int'(cfg_repeat) * $urandom_range(0, 4)
					+ $urandom_range(0, 3);
				if (len > 80)
					len = 80;
				repeat (len + 1)
					send_tick(1'b0, ub, db);
				send_tick(1'b0, 1'b0, 1'b0);
			end
			7: repeat ($urandom_range(1, 10)) send_tick(1'b0, 1'b0, 1'b0);
			default: repeat ($urandom_range(1, 6))
				send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
		endcase
	endtask

	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			clock_result_t want;
			gap = no_idle ? 0 : $urandom_range(0, TICK_GAP_MAX);
			if (gap > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction, count %0d mode %0d changed %0d",
					$time, out_ch.minute_count, out_ch.clock_mode, out_ch.count_changed);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.minute_count !== want.minute_count)
					report_mismatch("minute_count", want.minute_count, out_ch.minute_count);
				if (out_ch.clock_mode !== want.clock_mode)
					report_mismatch("clock_mode", want.clock_mode, out_ch.clock_mode);
				if (out_ch.count_changed !== want.count_changed)
					report_mismatch("count_changed", want.count_changed, out_ch.count_changed);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode_button = 1'b0;
		in_ch.up_button = 1'b0;
		in_ch.down_button = 1'b0;
		cfg_mph = MPH_RESET;
		cfg_run = RUN_PERIOD_RESET;
		cfg_hold = HOLD_DELAY_RESET;
		cfg_repeat = REPEAT_PERIOD_RESET;
		cur_mode = CODE_RUN;
		cur_count = COUNT_RESET;
		mode_seen = 1'b0;
		run_timer = '0;
		up_key = '0;
		down_key = '0;

		directed_rows = '{
			typed_row(1'b0, 1'b0, 1'b0, 2, CODE_RUN, 1'b0),
			typed_row(1'b1, 1'b1, 1'b1, 2, CODE_RUN, 1'b0),
			typed_row(1'b0, 1'b1, 1'b0, 2, CODE_HOURS, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b1, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			write_row(REG_HOLD_DELAY, 1),
			write_row(REG_REPEAT_PERIOD, 1),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			write_row(REG_MPH, 0),
			tick_row(1'b0, 1'b0, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			write_row(REG_MPH, 63),
			write_row(REG_RUN_PERIOD, 0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			write_row(REG_RUN_PERIOD, 1023),
			tick_row(1'b0, 1'b0, 1'b0)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_register(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				send_tick(directed_rows[i].mb, directed_rows[i].ub, directed_rows[i].db,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_register(REG_MPH, (p == 0) ? 63 : (p == 1) ? 0 : (p == 2) ? 3 :
				(p == 3) ? 60 : $urandom_range(0, 63));
			write_register(REG_RUN_PERIOD, (p == 0) ? 0 : (p == 1) ? 1023 : (p == 2) ? 1 :
				$urandom_range(0, 25));
			write_register(REG_HOLD_DELAY, (p == 0) ? 0 : (p == 1) ? 1023 : (p == 3) ? 1022 :
				$urandom_range(0, 30));
			write_register(REG_REPEAT_PERIOD, (p == 0) ? 0 : (p == 1 || p == 2) ? 1023 :
				$urandom_range(0, 12));
			no_idle = ($urandom_range(0, 3) == 0);
			if (p == 3) begin
				// A key held long enough to saturate its timer against a delay just below it.
				no_idle = 1'b1;
				while (cur_mode != CODE_HOURS) begin
					send_tick(1'b1, 1'b0, 1'b0);
					send_tick(1'b0, 1'b0, 1'b0);
				end
				repeat (LONG_HOLD_TICKS) send_tick(1'b0, 1'b1, 1'b0);
				send_tick(1'b0, 1'b0, 1'b0);
				no_idle = 1'b0;
			end
			phase_ticks = 0;
			while (phase_ticks < PHASE_TICKS)
				random_sequence();
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire
